// ===== sv/btc_pkg.sv =====
// Shared types and constants for the block transposition cipher.
package btc_pkg;

	localparam logic [7:0] PAD_BYTE = 8'h58;	// 'X'
	localparam logic [7:0] GAP_BYTE = 8'h20;	// ' '
	localparam int unsigned KEY_SLOTS = 8;

	typedef enum logic [1:0] {
		CFG_BLOCK_LENGTH  = 2'd0,
		CFG_KEY_POSITIONS = 2'd1,
		CFG_DIRECTION     = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// Where one output byte comes from: a stored byte or a fixed fill byte.
	typedef struct packed {
		logic       use_mem;
		logic [3:0] src;
		logic [7:0] fixed;
	} route_t;

endpackage

// ===== sv/btc_route.sv =====
// Key decode: picks the source of one output position of the block.
module btc_route (
	input  logic [23:0]        key_positions,
	input  logic [3:0]         len,
	input  logic [3:0]         fill,
	input  logic               direction,
	input  logic [2:0]         pos,
	output btc_pkg::route_t    route
);
	import btc_pkg::*;

	logic [2:0] enc_k;
	logic       dec_hit;
	logic [2:0] dec_src;
	logic       src_ok;
	logic [3:0] src;

	always_comb begin
		enc_k   = key_positions[3*pos +: 3];
		dec_hit = 1'b0;
		dec_src = 3'd0;
		// scatter: the highest key slot naming this position wins
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (4'(j) < len && key_positions[3*j +: 3] == pos) begin
				dec_hit = 1'b1;
				dec_src = 3'(j);
			end
		end
		if (direction) begin
			src_ok = dec_hit;
			src    = {1'b0, dec_src};
		end else begin
			src_ok = ({1'b0, enc_k} < len);
			src    = {1'b0, enc_k};
		end
		route.src = src;
		if (!src_ok) begin
			route.use_mem = 1'b0;
			route.fixed   = direction ? GAP_BYTE : PAD_BYTE;
		end else if (src < fill) begin
			route.use_mem = 1'b1;
			route.fixed   = PAD_BYTE;
		end else begin
			// past the gathered bytes of a short block
			route.use_mem = 1'b0;
			route.fixed   = PAD_BYTE;
		end
	end

endmodule

// ===== sv/block_transposition_cipher.sv =====
// Top level: block buffer memory, byte gather and keyed drain.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in       | in_valid / in_stall    | in_data  (data_byte, message_end)
//  out      | out_valid / out_stall  | out_data (out_byte, out_last)
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each taken input byte is written into the block memory.
// A flush drains the block one output byte at a time (memory read in ST_READ,
// then load of the output register in ST_LOAD).
// in_stall is high for the whole drain; the output register holds a byte
// while out_stall is high and the drain waits for it.
// Reset clears the fill count and loads the default configuration.
module block_transposition_cipher #(
	parameter int MAX_BLOCK = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  btc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output btc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	import btc_pkg::*;

	localparam int AW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int CAP = (MAX_BLOCK < KEY_SLOTS) ? MAX_BLOCK : KEY_SLOTS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t      state_q;
	logic [3:0]  block_length_q;
	logic [23:0] key_q;
	logic        direction_q;
	logic [3:0]  fill_q;
	logic        last_q;
	logic [2:0]  pos_q;
	route_t      route_s1;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [7:0]  mem [MAX_BLOCK];
	logic [7:0]  rd_data;

	logic [3:0]  len;
	logic [3:0]  fill_next;
	logic        in_take;
	logic        slot_free;
	logic        pos_last;
	route_t      route;

	always_comb begin
		if (block_length_q == 4'd0)
			len = 4'd1;
		else if (block_length_q > 4'(CAP))
			len = 4'(CAP);
		else
			len = block_length_q;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign fill_next = fill_q + 4'd1;
	assign slot_free = !out_valid_q || !out_stall;
	assign pos_last  = ({1'b0, pos_q} + 4'd1 == len);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	btc_route u_route (
		.key_positions (key_q),
		.len           (len),
		.fill          (fill_q),
		.direction     (direction_q),
		.pos           (pos_q),
		.route         (route)
	);

	// block memory: written during gather, read during drain
	always_ff @(posedge clk) begin
		if (in_take)
			mem[fill_q[AW-1:0]] <= in_data.data_byte;
		rd_data <= mem[route.src[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= 4'd8;
			key_q          <= 24'hFAC688;
			direction_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BLOCK_LENGTH:  block_length_q <= cfg_data[3:0];
				CFG_KEY_POSITIONS: key_q          <= cfg_data;
				CFG_DIRECTION:     direction_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= 4'd0;
			last_q      <= 1'b0;
			pos_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						fill_q <= fill_next;
						last_q <= in_data.message_end;
						pos_q  <= 3'd0;
						if (fill_next >= len || in_data.message_end)
							state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// wait for the output register to be free by the load cycle
					if (slot_free) begin
						route_s1 <= route;
						state_q  <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					out_valid_q      <= 1'b1;
					out_q.out_byte   <= route_s1.use_mem ? rd_data : route_s1.fixed;
					out_q.out_last   <= last_q && pos_last;
					if (pos_last) begin
						fill_q  <= 4'd0;
						state_q <= ST_IDLE;
					end else begin
						pos_q   <= pos_q + 3'd1;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/block_transposition_cipher_tb.sv =====
// Self-checking testbench for the block transposition cipher: directed and random traffic.
module block_transposition_cipher_tb;
	import btc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BLOCK = 8;
	localparam int RANDOM_ITEMS = 120;
	localparam int SETTLE_CYCLES = 8;
	localparam longint TIMEOUT_NS = 5_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_BLOCK_LENGTH;
	logic [23:0] cfg_data = '0;

	block_transposition_cipher #(.MAX_BLOCK(MAX_BLOCK)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// cipher state as the testbench sees it
	logic [7:0] held_bytes [MAX_BLOCK];
	logic [3:0] held_count = '0;
	logic [3:0] len_reg = 4'd8;
	logic [23:0] key_reg = 24'hFAC688;
	logic dir_reg = 1'b0;

	in_item_t pending_bytes[$];
	out_item_t expected_bytes[$];
	int mismatches = 0;
	int item_total = 0;

	// Gathers one byte; on a full block or message end, queues the permuted block.
	task automatic cipher_step(input in_item_t item);
		int unsigned n;
		logic [7:0] blk [MAX_BLOCK];
		logic [7:0] res [MAX_BLOCK];
		logic [2:0] k;
		out_item_t o;
		n = 32'(len_reg);
		if (n == 0) n = 1;
		if (n > MAX_BLOCK) n = MAX_BLOCK;
		if (n > KEY_SLOTS) n = KEY_SLOTS;
		if (held_count < MAX_BLOCK) held_bytes[held_count[2:0]] = item.data_byte;
		held_count = held_count + 4'd1;
		if (held_count < n && !item.message_end) return;
		for (int j = 0; j < n; j++)
			blk[j] = (j < held_count) ? held_bytes[j] : PAD_BYTE;
		if (!dir_reg) begin
			for (int j = 0; j < n; j++) begin
				k = key_reg[3*j +: 3];
				res[j] = (k < n) ? blk[k] : PAD_BYTE;
			end
		end else begin
			for (int j = 0; j < n; j++)
				res[j] = GAP_BYTE;
			// later entries overwrite earlier ones on duplicate positions
			for (int j = 0; j < n; j++) begin
				k = key_reg[3*j +: 3];
				if (k < n) res[k] = blk[j];
			end
		end
		for (int j = 0; j < n; j++) begin
			o.out_byte = res[j];
			o.out_last = item.message_end && (j == n - 1);
			expected_bytes = {expected_bytes, o};
		end
		held_count = '0;
	endtask

	// Input driver: bursts of random length with random gaps.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) cipher_step(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_bytes.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor; the stall pattern steps through four modes, picked by the top bits of a free-running counter.
	logic [10:0] stall_cycle;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_cycle <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected transfer, actual byte %02h last %0b",
						$time, out_data.out_byte, out_data.out_last);
					mismatches++;
				end else begin
					if (out_data.out_byte !== expected_bytes[0].out_byte) begin
						$display("%0t: out_byte expected %02h actual %02h", $time,
							expected_bytes[0].out_byte, out_data.out_byte);
						mismatches++;
					end
					if (out_data.out_last !== expected_bytes[0].out_last) begin
						$display("%0t: out_last expected %0b actual %0b", $time,
							expected_bytes[0].out_last, out_data.out_last);
						mismatches++;
					end
					void'(expected_bytes.pop_front());
				end
			end
			stall_cycle <= stall_cycle + 11'd1;
			case (stall_cycle[10:9])
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 3) == 0);
				2'd2: out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= stall_cycle[3];
			endcase
		end
	end

	task automatic send(input logic [7:0] data, input logic last);
		in_item_t item;
		item.data_byte = data;
		item.message_end = last;
		pending_bytes = {pending_bytes, item};
		item_total++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [23:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_BLOCK_LENGTH: len_reg = value[3:0];
			CFG_KEY_POSITIONS: key_reg = value;
			CFG_DIRECTION: dir_reg = value[0];
			default: ;
		endcase
	endtask

	initial begin
		#TIMEOUT_NS;
		$display("[block_transposition_cipher] ERROR");
		$finish;
	end

	initial begin
		int unsigned len_pick;
		int unsigned n;
		int unsigned rot;
		int phase_end;
		int msg_len;
		logic [23:0] value;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// default setup: identity key, full block, message ends on the block boundary
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h80, 1'b0);
		send(8'h7F, 1'b0);
		send(8'h01, 1'b0);
		send(8'hFE, 1'b0);
		send(PAD_BYTE, 1'b0);
		send(GAP_BYTE, 1'b1);
		wait_idle();

		// encrypt, length 3, one key entry past the block end; padded tail block
		write_reg(CFG_BLOCK_LENGTH, 24'h00_0003);
		write_reg(CFG_KEY_POSITIONS, {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd7, 3'd2});
		send(8'hAA, 1'b0);
		send(8'h55, 1'b0);
		send(8'h0F, 1'b0);
		send(8'hF0, 1'b1);
		wait_idle();

		// decrypt: duplicate entry, out of range entry, unnamed positions get spaces
		write_reg(CFG_DIRECTION, 24'h00_0001);
		write_reg(CFG_BLOCK_LENGTH, 24'h00_0004);
		write_reg(CFG_KEY_POSITIONS, {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd1, 3'd1});
		send(8'h11, 1'b0);
		send(8'h22, 1'b0);
		send(8'h33, 1'b1);
		wait_idle();

		// zero length acts as one
		write_reg(CFG_BLOCK_LENGTH, 24'hFFFFF0);
		send(8'h5A, 1'b0);
		send(8'hA5, 1'b1);
		wait_idle();

		// oversized length is clamped; all-ones key
		write_reg(CFG_BLOCK_LENGTH, 24'h00000F);
		write_reg(CFG_KEY_POSITIONS, 24'hFFFFFF);
		send(8'hC3, 1'b1);
		wait_idle();

		// length lowered mid-block: next byte flushes and drops the excess
		write_reg(CFG_DIRECTION, 24'hFFFFFE);
		write_reg(CFG_BLOCK_LENGTH, 24'h000008);
		write_reg(CFG_KEY_POSITIONS, 24'h000000);
		send(8'h10, 1'b0);
		send(8'h20, 1'b0);
		send(8'h30, 1'b0);
		send(8'h40, 1'b0);
		wait_idle();
		write_reg(CFG_BLOCK_LENGTH, 24'h000003);
		write_reg(CFG_KEY_POSITIONS, 24'hFAC688);
		send(8'h50, 1'b0);
		wait_idle();

		// random phases; a phase may stop mid-message, leaving a partial block
		phase_end = item_total;
		while (item_total < phase_end + RANDOM_ITEMS) begin
			len_pick = $urandom_range(0, 9);
			case (len_pick)
				0: value[3:0] = 4'd0;
				1: value[3:0] = 4'd1;
				2: value[3:0] = 4'd8;
				3: value[3:0] = 4'd15;
				default: value[3:0] = 4'($urandom_range(0, 15));
			endcase
			value[23:4] = 20'($urandom);
			n = (value[3:0] == 0) ? 1 : (value[3:0] > MAX_BLOCK ? MAX_BLOCK : value[3:0]);
			write_reg(CFG_BLOCK_LENGTH, value);

			case ($urandom_range(0, 4))
				0: value = 24'h000000;
				1: value = 24'hFFFFFF;
				2: value = 24'($urandom);
				default: begin
					// rotation within the block: a true permutation
					rot = $urandom_range(0, n - 1);
					value = 24'($urandom);
					for (int j = 0; j < n; j++)
						value[3*j +: 3] = 3'((j + rot) % n);
				end
			endcase
			write_reg(CFG_KEY_POSITIONS, value);
			value = 24'($urandom);
			write_reg(CFG_DIRECTION, value);

			begin
				int stop_at;
				stop_at = item_total + $urandom_range(8, 24);
				while (item_total < stop_at) begin
					msg_len = $urandom_range(1, 12);
					for (int b = 0; b < msg_len && item_total < stop_at; b++)
						send(8'($urandom_range(0, 255)), b == msg_len - 1);
				end
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("[block_transposition_cipher] OK");
		end else begin
			$display("[block_transposition_cipher] ERROR");
		end
		$finish;
	end

endmodule
